### rtl/psl_pkg.sv
`timescale 1ns / 1ps

package psl_pkg;

  // field and state widths
  localparam int CHANNELS    = 2;
  localparam int CH_W        = 1;
  localparam int SAMPLE_BITS = 16;
  localparam int PHASE_W     = 32;
  localparam int TICK_W      = 20;
  localparam int SHAPE_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // reset values of the configuration registers
  localparam int SHAPE_RESET = 4096;
  localparam int SPS_RESET   = 48000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_EXP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_SEC = 2'd2;

  // shaper datapath
  localparam int X_W        = SAMPLE_BITS;
  localparam int N_W        = $clog2(X_W);
  localparam int Y_W        = 31;
  localparam int SH_W       = $clog2(Y_W);
  localparam int FRAC_BITS  = 16;
  localparam int LOG_CNT_W  = $clog2(FRAC_BITS);
  localparam int NEG_W      = N_W + FRAC_BITS;
  localparam int PROD_W     = NEG_W + SHAPE_W;
  localparam int MUL_SHIFT  = 12;
  localparam int MUL_ROUND  = 1 << (MUL_SHIFT - 1);
  localparam int T_W        = PROD_W - MUL_SHIFT;
  localparam int IP_W       = 5;
  localparam int IP_MAX     = 31;
  localparam int V_W        = 31;
  localparam int V_ONE      = 1 << 30;
  localparam int RAD_W      = 2 * V_W;
  localparam int REM_W      = 32;
  localparam int ROOT_STEPS = V_W;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
  localparam int OUT_SHIFT  = 31 - SAMPLE_BITS;
  localparam int OUT_ROUND  = 1 << (OUT_SHIFT - 1);

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CH_W-1:0] chan;
    logic            negative;
    logic            zero;
    logic [X_W-1:0]  mag;
  } psl_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } psl_qstat_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_inc;
    logic [SHAPE_W-1:0] shape_exp;
    logic [TICK_W-1:0]  sps;
  } psl_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOG,
    ST_MUL,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_SCALE
  } psl_state_t;

endpackage

### rtl/psl_front.sv
`timescale 1ns / 1ps

module psl_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic [psl_pkg::CH_W-1:0] in_channel,
  input  psl_pkg::psl_cfg_t       cfg,
  input  psl_pkg::psl_qstat_t     qstat,
  output logic                    q_push,
  output psl_pkg::psl_item_t      q_item
);
  import psl_pkg::*;

  logic [PHASE_W-1:0] phase_r [CHANNELS];
  logic [TICK_W-1:0]  tick_r  [CHANNELS];

  logic [PHASE_W-1:0] phase_cur, p, m;
  logic [TICK_W-1:0]  tick_cur;
  logic [TICK_W:0]    tick_inc;
  logic               wrap, negative;
  logic [PHASE_W-1:0] phase_nxt;
  logic [TICK_W-1:0]  tick_nxt;
  logic [X_W-1:0]     mag;

  assign q_push = push && !qstat.full;

  always_comb begin
    phase_cur = phase_r[in_channel];
    tick_cur  = tick_r[in_channel];
    p         = phase_cur + 32'h8000_0000;
    negative  = ~p[PHASE_W-1];
    m         = negative ? (32'h8000_0000 - p) : {1'b0, p[PHASE_W-2:0]};
    mag       = m[PHASE_W-1:PHASE_W-X_W];
    tick_inc  = {1'b0, tick_cur} + {{TICK_W{1'b0}}, 1'b1};
    wrap      = tick_inc >= {1'b0, cfg.sps};
    phase_nxt = wrap ? '0 : phase_cur + cfg.phase_inc;
    tick_nxt  = wrap ? '0 : tick_inc[TICK_W-1:0];
  end

  always_comb begin
    q_item.chan     = in_channel;
    q_item.negative = negative;
    q_item.zero     = (mag == '0);
    q_item.mag      = mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        phase_r[c] <= '0;
        tick_r[c]  <= '0;
      end
    end else if (q_push) begin
      phase_r[in_channel] <= phase_nxt;
      tick_r[in_channel]  <= tick_nxt;
    end
  end

endmodule

### rtl/psl_queue.sv
`timescale 1ns / 1ps

module psl_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  psl_pkg::psl_item_t  wr_item,
  input  logic                pop,
  output psl_pkg::psl_item_t  rd_item,
  output psl_pkg::psl_qstat_t stat
);
  import psl_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  psl_item_t        store_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    ptr_inc = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  assign rd_item    = store_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("queue read while empty");

endmodule

### rtl/psl_back.sv
`timescale 1ns / 1ps

module psl_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  psl_pkg::psl_qstat_t             qstat,
  input  psl_pkg::psl_item_t              q_item,
  input  logic [psl_pkg::SHAPE_W-1:0]     shape_exp,
  input  logic                            pop,
  output logic                            q_pop,
  output logic                            empty,
  output logic [psl_pkg::CH_W-1:0]        out_channel_out,
  output logic signed [psl_pkg::SAMPLE_BITS-1:0] out_wave_sample
);
  import psl_pkg::*;

  psl_state_t state_r, state_nxt;

  logic [CH_W-1:0]       chan_r, chan_nxt;
  logic                  neg_r, neg_nxt;
  logic [N_W-1:0]        n_r, n_nxt;
  logic [Y_W-1:0]        y_r, y_nxt;
  logic [FRAC_BITS-1:0]  frac_r, frac_nxt;
  logic [LOG_CNT_W-1:0]  log_cnt_r, log_cnt_nxt;
  logic [IP_W-1:0]       ip_r, ip_nxt;
  logic [FRAC_BITS-1:0]  f_r, f_nxt;
  logic [LOG_CNT_W-1:0]  bit_r, bit_nxt;
  logic [V_W-1:0]        v_r, v_nxt;
  logic [RAD_W-1:0]      rad_r, rad_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [V_W-1:0]        root_r, root_nxt;
  logic [ROOT_CNT_W-1:0] root_cnt_r, root_cnt_nxt;

  logic                   out_valid_r;
  logic [CH_W-1:0]        out_chan_r;
  logic [SAMPLE_BITS-1:0] out_wave_r, wave_nxt;

  logic out_free, out_load;

  // normalise
  logic [N_W-1:0]  n_enc;
  logic [SH_W-1:0] norm_sh;
  logic [Y_W-1:0]  y_norm;
  // squaring log
  logic [2*Y_W-1:0] sq;
  logic [Y_W:0]     sq_hi;
  // exponent product
  logic [N_W-1:0]    int_part;
  logic [NEG_W-1:0]  neg_val;
  logic [PROD_W-1:0] prod;
  logic [T_W-1:0]    t_val;
  logic [T_W-FRAC_BITS-1:0] ip_raw;
  // root step
  logic [V_W-1:0]   v_half;
  logic [REM_W+1:0] rem_sh, trial, rem_sub;
  logic             take;
  // output scaling
  logic [V_W-1:0]         v_sh;
  logic [V_W:0]           round_sum;
  logic [SAMPLE_BITS-1:0] q_mag;

  assign out_free = !out_valid_r || pop;

  always_comb begin
    n_enc = '0;
    for (int i = 0; i < X_W; i++) begin
      if (q_item.mag[i]) n_enc = N_W'(i);
    end
    norm_sh = SH_W'(Y_W - 1) - SH_W'(n_enc);
    y_norm  = Y_W'(q_item.mag) << norm_sh;
  end

  always_comb begin
    sq    = (2 * Y_W)'(y_r) * (2 * Y_W)'(y_r);
    sq_hi = sq[2*Y_W-1:Y_W-1];
  end

  always_comb begin
    int_part = N_W'(SAMPLE_BITS - 1) - n_r;
    neg_val  = {int_part, {FRAC_BITS{1'b0}}} - NEG_W'(frac_r);
    prod     = PROD_W'(neg_val) * PROD_W'(shape_exp) + PROD_W'(MUL_ROUND);
    t_val    = prod[PROD_W-1:MUL_SHIFT];
    ip_raw   = t_val[T_W-1:FRAC_BITS];
  end

  always_comb begin
    v_half  = f_r[bit_r] ? (v_r >> 1) : v_r;
    rem_sh  = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
    trial   = {1'b0, root_r, 2'b01};
    take    = rem_sh >= trial;
    rem_sub = rem_sh - trial;
  end

  always_comb begin
    v_sh      = (ip_r == IP_W'(IP_MAX)) ? '0 : (v_r >> ip_r);
    round_sum = {1'b0, v_sh} + (V_W + 1)'(OUT_ROUND);
    q_mag     = round_sum[V_W-1:OUT_SHIFT];
    if (neg_r) begin
      wave_nxt = '0 - q_mag;
    end else if (q_mag > SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1)) begin
      wave_nxt = SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    end else begin
      wave_nxt = q_mag;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!qstat.empty) state_nxt = q_item.zero ? ST_SCALE : ST_LOG;
      end
      ST_LOG: begin
        if (log_cnt_r == LOG_CNT_W'(FRAC_BITS - 1)) state_nxt = ST_MUL;
      end
      ST_MUL:       state_nxt = ST_ROOT_LOAD;
      ST_ROOT_LOAD: state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (root_cnt_r == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
          state_nxt = (bit_r == LOG_CNT_W'(FRAC_BITS - 1)) ? ST_SCALE : ST_ROOT_LOAD;
        end
      end
      ST_SCALE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = (state_r == ST_IDLE) && !qstat.empty;
    out_load = (state_r == ST_SCALE) && out_free;
  end

  // datapath
  always_comb begin
    chan_nxt     = chan_r;
    neg_nxt      = neg_r;
    n_nxt        = n_r;
    y_nxt        = y_r;
    frac_nxt     = frac_r;
    log_cnt_nxt  = log_cnt_r;
    ip_nxt       = ip_r;
    f_nxt        = f_r;
    bit_nxt      = bit_r;
    v_nxt        = v_r;
    rad_nxt      = rad_r;
    rem_nxt      = rem_r;
    root_nxt     = root_r;
    root_cnt_nxt = root_cnt_r;
    case (state_r)
      ST_IDLE: begin
        chan_nxt    = q_item.chan;
        neg_nxt     = q_item.negative;
        n_nxt       = n_enc;
        y_nxt       = y_norm;
        frac_nxt    = '0;
        log_cnt_nxt = '0;
        // silent sample goes straight to scaling with a zero value
        v_nxt       = '0;
        ip_nxt      = '0;
      end
      ST_LOG: begin
        y_nxt       = sq_hi[Y_W] ? sq_hi[Y_W:1] : sq_hi[Y_W-1:0];
        frac_nxt    = {frac_r[FRAC_BITS-2:0], sq_hi[Y_W]};
        log_cnt_nxt = log_cnt_r + LOG_CNT_W'(1);
      end
      ST_MUL: begin
        ip_nxt  = (ip_raw > (T_W - FRAC_BITS)'(IP_MAX)) ? IP_W'(IP_MAX) : ip_raw[IP_W-1:0];
        f_nxt   = t_val[FRAC_BITS-1:0];
        v_nxt   = V_W'(V_ONE);
        bit_nxt = '0;
      end
      ST_ROOT_LOAD: begin
        rad_nxt      = {1'b0, v_half, {(RAD_W - V_W - 1){1'b0}}};
        rem_nxt      = '0;
        root_nxt     = '0;
        root_cnt_nxt = '0;
      end
      ST_ROOT: begin
        rad_nxt      = rad_r << 2;
        rem_nxt      = take ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_nxt     = {root_r[V_W-2:0], take};
        root_cnt_nxt = root_cnt_r + ROOT_CNT_W'(1);
        if (root_cnt_r == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
          v_nxt   = {root_r[V_W-2:0], take};
          bit_nxt = bit_r + LOG_CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    chan_r     <= chan_nxt;
    neg_r      <= neg_nxt;
    n_r        <= n_nxt;
    y_r        <= y_nxt;
    frac_r     <= frac_nxt;
    log_cnt_r  <= log_cnt_nxt;
    ip_r       <= ip_nxt;
    f_r        <= f_nxt;
    bit_r      <= bit_nxt;
    v_r        <= v_nxt;
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    root_cnt_r <= root_cnt_nxt;
    if (out_load) begin
      out_chan_r <= chan_r;
      out_wave_r <= wave_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load)  out_valid_r <= 1'b1;
      else if (pop)  out_valid_r <= 1'b0;
    end
  end

  assign empty           = !out_valid_r;
  assign out_channel_out = out_chan_r;
  assign out_wave_sample = out_wave_r;

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("finished sample not held in output register");

  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != ST_IDLE))
    else $error("item taken from queue but shaper stayed idle");

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCALE) |-> (v_r <= V_W'(V_ONE)))
    else $error("exp2 result above unity");

endmodule

### rtl/power_shaped_saw_lfo.sv
`timescale 1ns / 1ps
// steps from input transfer to result on the output ports, set by the shaper: 16 log squarings,
//   one multiply, 16 roots, then scaling; a zero sawtooth magnitude goes straight to scaling
// flow: the shaper finishes one sample before it takes the next; a 2-entry queue and the
//   output register let the input side take items while the shaper is busy
// reset: synchronous, active low; clears per-channel phase and tick count, queue and output
//   valid flag; loads register defaults (increment 0, exponent 1.0, 48000 ticks)

module power_shaped_saw_lfo (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // sample tick channel
  input  logic                                   push,
  output logic                                   full,
  input  logic [psl_pkg::CH_W-1:0]               in_channel,
  // result channel
  output logic                                   empty,
  input  logic                                   pop,
  output logic [psl_pkg::CH_W-1:0]               out_channel_out,
  output logic signed [psl_pkg::SAMPLE_BITS-1:0] out_wave_sample,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [psl_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [psl_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import psl_pkg::*;

  psl_cfg_t   cfg_r;
  psl_qstat_t qstat;
  psl_item_t  fe_item, be_item;
  logic       q_push, q_pop;

  // register file, always ready; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_inc <= '0;
      cfg_r.shape_exp <= SHAPE_W'(SHAPE_RESET);
      cfg_r.sps       <= TICK_W'(SPS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PHASE_INC:   cfg_r.phase_inc <= cfg_data[PHASE_W-1:0];
        CFG_SHAPE_EXP:   cfg_r.shape_exp <= cfg_data[SHAPE_W-1:0];
        CFG_SAMPLES_SEC: cfg_r.sps       <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // the tick side stalls only when the queue is full
  assign full = qstat.full;

  // front: phase and tick bookkeeping, sawtooth sign and magnitude
  psl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_channel (in_channel),
    .cfg        (cfg_r),
    .qstat      (qstat),
    .q_push     (q_push),
    .q_item     (fe_item)
  );

  // short queue decoupling the tick side from the shaper
  psl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (fe_item),
    .pop     (q_pop),
    .rd_item (be_item),
    .stat    (qstat)
  );

  // back: log2, exponent multiply, square-root exp2, rounding and output register
  psl_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .qstat           (qstat),
    .q_item          (be_item),
    .shape_exp       (cfg_r.shape_exp),
    .pop             (pop),
    .q_pop           (q_pop),
    .empty           (empty),
    .out_channel_out (out_channel_out),
    .out_wave_sample (out_wave_sample)
  );

endmodule
